// ===== rtl/nfs4_acl_pkg.sv =====
package nfs4_acl_pkg;

	localparam int MaskW = 32;

	typedef enum logic [2:0] {
		WHO_OWNER = 3'd0,
		WHO_USER = 3'd1,
		WHO_GROUP_OBJ = 3'd2,
		WHO_GROUP = 3'd3,
		WHO_EVERYONE = 3'd4
	} who_t;

	typedef enum logic [2:0] {
		TAG_USER_OBJ = 3'd0,
		TAG_USER = 3'd1,
		TAG_GROUP_OBJ = 3'd2,
		TAG_GROUP = 3'd3,
		TAG_MASK = 3'd4,
		TAG_OTHER = 3'd5,
		TAG_EMPTY = 3'd6,
		TAG_ERROR = 3'd7
	} tag_t;

	typedef enum logic [2:0] {
		CFG_IS_DIR = 3'd0,
		CFG_WANT_DEF = 3'd1,
		CFG_READ = 3'd2,
		CFG_WRITE = 3'd3,
		CFG_EXEC = 3'd4,
		CFG_DEL_CHILD = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [MaskW-1:0] id;
		logic [MaskW-1:0] allow;
		logic [MaskW-1:0] deny;
	} named_t;

	typedef struct packed {
		logic is_dir;
		logic want_def;
		logic [MaskW-1:0] read_bits;
		logic [MaskW-1:0] write_bits;
		logic [MaskW-1:0] exec_bits;
		logic [MaskW-1:0] del_bits;
	} cfg_t;

	function automatic logic [MaskW-1:0] fold(input logic [MaskW-1:0] own,
			input logic [MaskW-1:0] other, input logic [MaskW-1:0] m);
		fold = own | (m & ~other);
	endfunction

endpackage

// ===== rtl/nfs4_acl_mapper_core.sv =====
module nfs4_acl_mapper_core #(
	parameter int MAX_NAMED = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  nfs4_acl_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic [2:0] who_kind,
	input  logic is_allow,
	input  logic [31:0] ace_mask,
	input  logic [31:0] principal_id,
	input  logic inherits,
	input  logic inherit_only,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] entry_tag,
	output logic [31:0] qualifier,
	output logic may_read,
	output logic may_write,
	output logic may_execute,
	output logic last_entry
);
	localparam int IW = (MAX_NAMED > 1) ? $clog2(MAX_NAMED) : 1;
	localparam int CW = $clog2(MAX_NAMED + 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SRCH = 9'b000000010,
		ST_UPD = 9'b000000100,
		ST_SPRD = 9'b000001000,
		ST_E_OWN = 9'b000010000,
		ST_E_USR = 9'b000100000,
		ST_E_GOB = 9'b001000000,
		ST_E_GRP = 9'b010000000,
		ST_E_TAIL = 9'b100000000
	} state_t;

	state_t st_q;
	nfs4_acl_pkg::named_t utab [MAX_NAMED];
	nfs4_acl_pkg::named_t gtab [MAX_NAMED];
	logic [31:0] own_a_q, own_d_q, grp_a_q, grp_d_q, oth_a_q, oth_d_q, evr_a_q, evr_d_q;
	logic [CW-1:0] ucnt_q, gcnt_q;
	logic [15:0] kept_q;
	logic ovf_q;
	logic [2:0] who_q;
	logic allow_q, tabg_q;
	logic [31:0] m_q, id_q, sprd_q, union_q;
	logic [CW-1:0] idx_q;
	logic hit_q;
	logic [CW-1:0] hidx_q;
	logic emit_q;
	logic tail_mask_q;

	logic [IW-1:0] ia;
	logic [CW-1:0] cnt;
	nfs4_acl_pkg::named_t ent;
	logic [31:0] wm, perm;
	logic out_fire, do_clear;

	assign ia = idx_q[IW-1:0];
	assign cnt = tabg_q ? gcnt_q : ucnt_q;
	assign ent = tabg_q ? gtab[ia] : utab[ia];
	assign wm = cfg.write_bits | (cfg.is_dir ? cfg.del_bits : 32'd0);
	assign in_ready = (st_q == ST_IDLE) && !out_valid;
	assign out_fire = out_valid && out_ready;

	always_comb begin
		case (st_q)
			ST_E_OWN: perm = own_a_q;
			ST_E_USR: perm = utab[ia].allow;
			ST_E_GOB: perm = grp_a_q;
			ST_E_GRP: perm = gtab[ia].allow;
			default: perm = tail_mask_q ? union_q : oth_a_q;
		endcase
	end

	assign do_clear = out_fire && last_entry;

	always_ff @(posedge clk) begin
		if (st_q == ST_SRCH && idx_q >= cnt && idx_q < CW'(MAX_NAMED)) begin
			// append seeded entry
			if (tabg_q) begin
				gtab[ia].id <= id_q;
				gtab[ia].allow <= oth_a_q;
				gtab[ia].deny <= oth_d_q;
			end else begin
				utab[ia].id <= id_q;
				utab[ia].allow <= evr_a_q;
				utab[ia].deny <= evr_d_q;
			end
		end
		if (st_q == ST_UPD && !hit_q) begin
			if (tabg_q) begin
				if (allow_q) gtab[hidx_q[IW-1:0]].allow <=
					nfs4_acl_pkg::fold(gtab[hidx_q[IW-1:0]].allow, gtab[hidx_q[IW-1:0]].deny, m_q);
				else gtab[hidx_q[IW-1:0]].deny <=
					nfs4_acl_pkg::fold(gtab[hidx_q[IW-1:0]].deny, gtab[hidx_q[IW-1:0]].allow, m_q);
			end else begin
				if (allow_q) utab[hidx_q[IW-1:0]].allow <=
					nfs4_acl_pkg::fold(utab[hidx_q[IW-1:0]].allow, utab[hidx_q[IW-1:0]].deny, m_q);
				else utab[hidx_q[IW-1:0]].deny <=
					nfs4_acl_pkg::fold(utab[hidx_q[IW-1:0]].deny, utab[hidx_q[IW-1:0]].allow, m_q);
			end
		end
		if (st_q == ST_SPRD && idx_q < cnt) begin
			// walk one table entry per cycle with the shared fold
			if (tabg_q) begin
				if (allow_q) gtab[ia].allow <= nfs4_acl_pkg::fold(ent.allow, ent.deny, sprd_q);
				else gtab[ia].deny <= nfs4_acl_pkg::fold(ent.deny, ent.allow, sprd_q);
			end else begin
				if (allow_q) utab[ia].allow <= nfs4_acl_pkg::fold(ent.allow, ent.deny, sprd_q);
				else utab[ia].deny <= nfs4_acl_pkg::fold(ent.deny, ent.allow, sprd_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			own_a_q <= '0; own_d_q <= '0; grp_a_q <= '0; grp_d_q <= '0;
			oth_a_q <= '0; oth_d_q <= '0; evr_a_q <= '0; evr_d_q <= '0;
			ucnt_q <= '0; gcnt_q <= '0; kept_q <= '0; ovf_q <= 1'b0;
			out_valid <= 1'b0;
			emit_q <= 1'b0;
			who_q <= '0; allow_q <= 1'b0; tabg_q <= 1'b0;
			m_q <= '0; id_q <= '0; sprd_q <= '0; union_q <= '0;
			idx_q <= '0; hit_q <= 1'b0; hidx_q <= '0; tail_mask_q <= 1'b0;
			entry_tag <= '0; qualifier <= '0; may_read <= 1'b0; may_write <= 1'b0;
			may_execute <= 1'b0; last_entry <= 1'b0;
		end else begin
			if (out_fire) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						who_q <= who_kind; allow_q <= is_allow;
						m_q <= ace_mask; id_q <= principal_id;
						idx_q <= '0;
						if (req_type) begin
							if ((cfg.want_def && !cfg.is_dir) || ovf_q ||
									(cfg.want_def && kept_q == 16'd0)) begin
								out_valid <= 1'b1;
								entry_tag <= (cfg.want_def && kept_q == 16'd0 && cfg.is_dir
									&& !ovf_q) ? nfs4_acl_pkg::TAG_EMPTY : nfs4_acl_pkg::TAG_ERROR;
								qualifier <= '0; may_read <= 1'b0; may_write <= 1'b0;
								may_execute <= 1'b0; last_entry <= 1'b1;
							end else begin
								union_q <= '0; tail_mask_q <= 1'b0;
								emit_q <= 1'b0;
								st_q <= ST_E_OWN;
							end
						end else if (cfg.want_def ? inherits : !inherit_only) begin
							if (kept_q != 16'hFFFF) kept_q <= kept_q + 16'd1;
							case (who_kind)
								nfs4_acl_pkg::WHO_OWNER: begin
									if (is_allow) own_a_q <= nfs4_acl_pkg::fold(own_a_q, own_d_q, ace_mask);
									else own_d_q <= nfs4_acl_pkg::fold(own_d_q, own_a_q, ace_mask);
								end
								nfs4_acl_pkg::WHO_USER: begin
									tabg_q <= 1'b0; hit_q <= 1'b0; st_q <= ST_SRCH;
								end
								nfs4_acl_pkg::WHO_GROUP: begin
									tabg_q <= 1'b1; hit_q <= 1'b0; st_q <= ST_SRCH;
								end
								nfs4_acl_pkg::WHO_GROUP_OBJ: begin
									if (is_allow) begin
										grp_a_q <= nfs4_acl_pkg::fold(grp_a_q, grp_d_q, ace_mask);
										sprd_q <= nfs4_acl_pkg::fold(grp_a_q, grp_d_q, ace_mask);
										tabg_q <= 1'b1; hit_q <= 1'b1;
										st_q <= ST_UPD;
									end else grp_d_q <= nfs4_acl_pkg::fold(grp_d_q, grp_a_q, ace_mask);
								end
								nfs4_acl_pkg::WHO_EVERYONE: begin
									if (is_allow) begin
										own_a_q <= nfs4_acl_pkg::fold(own_a_q, own_d_q, ace_mask);
										grp_a_q <= nfs4_acl_pkg::fold(grp_a_q, grp_d_q, ace_mask);
										oth_a_q <= nfs4_acl_pkg::fold(oth_a_q, oth_d_q, ace_mask);
										evr_a_q <= nfs4_acl_pkg::fold(evr_a_q, evr_d_q, ace_mask);
									end else begin
										own_d_q <= nfs4_acl_pkg::fold(own_d_q, own_a_q, ace_mask);
										grp_d_q <= nfs4_acl_pkg::fold(grp_d_q, grp_a_q, ace_mask);
										oth_d_q <= nfs4_acl_pkg::fold(oth_d_q, oth_a_q, ace_mask);
										evr_d_q <= nfs4_acl_pkg::fold(evr_d_q, evr_a_q, ace_mask);
									end
									sprd_q <= ace_mask; tabg_q <= 1'b0;
									st_q <= ST_SPRD;
								end
								default: ;
							endcase
						end
					end
				end
				ST_SRCH: begin
					if (idx_q < cnt && idx_q < CW'(MAX_NAMED)) begin
						if (ent.id == id_q) begin
							hidx_q <= idx_q; st_q <= ST_UPD;
						end else idx_q <= idx_q + 1'b1;
					end else if (idx_q >= CW'(MAX_NAMED)) begin
						ovf_q <= 1'b1; st_q <= ST_IDLE;
					end else begin
						// new entry written this cycle, update next
						hidx_q <= idx_q;
						if (tabg_q) gcnt_q <= gcnt_q + 1'b1;
						else ucnt_q <= ucnt_q + 1'b1;
						st_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// group_obj arrives here with hit_q set and nothing to update in a table
					if (hit_q) begin
						own_a_q <= nfs4_acl_pkg::fold(own_a_q, own_d_q, sprd_q);
						evr_a_q <= nfs4_acl_pkg::fold(evr_a_q, evr_d_q, sprd_q);
						tabg_q <= 1'b0; idx_q <= '0; st_q <= ST_SPRD;
					end else if (allow_q) begin
						hit_q <= 1'b1;
						sprd_q <= tabg_q ?
							nfs4_acl_pkg::fold(gtab[hidx_q[IW-1:0]].allow, gtab[hidx_q[IW-1:0]].deny, m_q) :
							nfs4_acl_pkg::fold(utab[hidx_q[IW-1:0]].allow, utab[hidx_q[IW-1:0]].deny, m_q);
						if (!tabg_q) begin
							// named user spreads only to owner
							own_a_q <= nfs4_acl_pkg::fold(own_a_q, own_d_q,
								nfs4_acl_pkg::fold(utab[hidx_q[IW-1:0]].allow,
									utab[hidx_q[IW-1:0]].deny, m_q));
							st_q <= ST_IDLE;
						end
					end else st_q <= ST_IDLE;
				end
				ST_SPRD: begin
					if (idx_q < cnt) idx_q <= idx_q + 1'b1;
					else if (who_q == nfs4_acl_pkg::WHO_EVERYONE && !tabg_q) begin
						tabg_q <= 1'b1; idx_q <= '0;
					end else st_q <= ST_IDLE;
				end
				ST_E_OWN, ST_E_USR, ST_E_GOB, ST_E_GRP, ST_E_TAIL: begin
					if (!out_valid || out_fire) begin
						if (emit_q) begin
							emit_q <= 1'b0;
							if (do_clear) begin
								own_a_q <= '0; own_d_q <= '0; grp_a_q <= '0; grp_d_q <= '0;
								oth_a_q <= '0; oth_d_q <= '0; evr_a_q <= '0; evr_d_q <= '0;
								ucnt_q <= '0; gcnt_q <= '0; kept_q <= '0; ovf_q <= 1'b0;
								st_q <= ST_IDLE;
							end
						end else begin
							out_valid <= 1'b1; emit_q <= 1'b1;
							may_read <= |(perm & cfg.read_bits);
							may_write <= |(perm & wm);
							may_execute <= |(perm & cfg.exec_bits);
							qualifier <= '0; last_entry <= 1'b0;
							case (st_q)
								ST_E_OWN: begin
									entry_tag <= nfs4_acl_pkg::TAG_USER_OBJ;
									idx_q <= '0;
								end
								ST_E_USR: begin
									entry_tag <= nfs4_acl_pkg::TAG_USER;
									qualifier <= utab[ia].id;
									union_q <= union_q | utab[ia].allow;
									idx_q <= idx_q + 1'b1;
								end
								ST_E_GOB: begin
									entry_tag <= nfs4_acl_pkg::TAG_GROUP_OBJ;
									union_q <= union_q | grp_a_q;
									idx_q <= '0;
								end
								ST_E_GRP: begin
									entry_tag <= nfs4_acl_pkg::TAG_GROUP;
									qualifier <= gtab[ia].id;
									union_q <= union_q | gtab[ia].allow;
									idx_q <= idx_q + 1'b1;
								end
								default: begin
									if (tail_mask_q) begin
										entry_tag <= nfs4_acl_pkg::TAG_MASK;
										tail_mask_q <= 1'b0;
									end else begin
										entry_tag <= nfs4_acl_pkg::TAG_OTHER;
										last_entry <= 1'b1;
									end
								end
							endcase
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			// pick the next emit phase once the current beat is loaded
			if (emit_q && (!out_valid || out_fire) && !do_clear) begin
				case (st_q)
					ST_E_OWN: st_q <= (ucnt_q != '0) ? ST_E_USR : ST_E_GOB;
					ST_E_USR: if (idx_q >= ucnt_q) st_q <= ST_E_GOB;
					ST_E_GOB: if (gcnt_q != '0) st_q <= ST_E_GRP;
						else begin
							st_q <= ST_E_TAIL; tail_mask_q <= (ucnt_q != '0);
						end
					ST_E_GRP: if (idx_q >= gcnt_q) begin
							st_q <= ST_E_TAIL; tail_mask_q <= 1'b1;
						end
					default: ;
				endcase
			end
			if (st_q == ST_IDLE && out_valid && out_fire && last_entry && !emit_q) begin
				own_a_q <= '0; own_d_q <= '0; grp_a_q <= '0; grp_d_q <= '0;
				oth_a_q <= '0; oth_d_q <= '0; evr_a_q <= '0; evr_d_q <= '0;
				ucnt_q <= '0; gcnt_q <= '0; kept_q <= '0; ovf_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_u: assert property (@(posedge clk) disable iff (!arst_n) ucnt_q <= CW'(MAX_NAMED))
		else $error("user count beyond table");
	a_cnt_g: assert property (@(posedge clk) disable iff (!arst_n) gcnt_q <= CW'(MAX_NAMED))
		else $error("group count beyond table");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_entry) |=> (ucnt_q == '0 && gcnt_q == '0 && kept_q == '0))
		else $error("state not cleared after list");
`endif
endmodule

// ===== rtl/nfs4_acl_cfg_regs.sv =====
module nfs4_acl_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	output nfs4_acl_pkg::cfg_t cfg
);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.is_dir <= 1'b0; cfg.want_def <= 1'b0;
			cfg.read_bits <= 32'd1; cfg.write_bits <= 32'd6;
			cfg.exec_bits <= 32'd32; cfg.del_bits <= 32'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				nfs4_acl_pkg::CFG_IS_DIR: cfg.is_dir <= cfg_data[0];
				nfs4_acl_pkg::CFG_WANT_DEF: cfg.want_def <= cfg_data[0];
				nfs4_acl_pkg::CFG_READ: cfg.read_bits <= cfg_data;
				nfs4_acl_pkg::CFG_WRITE: cfg.write_bits <= cfg_data;
				nfs4_acl_pkg::CFG_EXEC: cfg.exec_bits <= cfg_data;
				nfs4_acl_pkg::CFG_DEL_CHILD: cfg.del_bits <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/nfs4_to_posix_acl_mapper.sv =====
// NFSv4 ACE to POSIX ACL mapper.
// Input channel (in_valid/in_ready): one ACE per beat with req_type 0, or a
// finish request with req_type 1. Output channel (out_valid/out_ready): POSIX
// entries, user_obj, named users, group_obj, named groups, mask, other; the
// final beat carries last_entry. Config channel (cfg_valid/cfg_ready) writes a
// register by index, always ready; write only while idle.
// Owner ACEs and group_obj denies are folded in idle; a named ACE searches its table
// one entry per cycle; allows that spread to the named users walk that table too,
// and everyone ACEs walk both tables. No new ACE is taken until its walk is done;
// the table walk sets the rate.
// The first beat of a finish is loaded in the E_OWN state after acceptance; an
// error or empty-ACL beat is valid in the cycle after acceptance.
// A finish emits one beat at a time and holds while out_ready is low;
// no new item is taken until the list has drained.
// Reset clears all masks, counts and the overflow flag and loads register
// defaults; table contents stay undefined until written.
module nfs4_to_posix_acl_mapper #(
	parameter int MAX_NAMED = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic [2:0] who_kind,
	input  logic is_allow,
	input  logic [31:0] ace_mask,
	input  logic [31:0] principal_id,
	input  logic inherits,
	input  logic inherit_only,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] entry_tag,
	output logic [31:0] qualifier,
	output logic may_read,
	output logic may_write,
	output logic may_execute,
	output logic last_entry
);
	nfs4_acl_pkg::cfg_t cfg;

	nfs4_acl_cfg_regs u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
	);

	nfs4_acl_mapper_core #(.MAX_NAMED(MAX_NAMED)) u_core (
		.clk, .arst_n, .cfg, .in_valid, .in_ready, .req_type, .who_kind, .is_allow,
		.ace_mask, .principal_id, .inherits, .inherit_only, .out_valid,
		.out_ready, .entry_tag, .qualifier, .may_read, .may_write, .may_execute,
		.last_entry
	);
endmodule

// ===== tb/sv/nfs4_to_posix_acl_mapper_test.sv =====
`timescale 1ns / 100ps

module nfs4_to_posix_acl_mapper_test;

	localparam int NAMED_MAX = 16;
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic [2:0] tag;
		logic [31:0] qual;
		logic rd;
		logic wr;
		logic ex;
		logic last;
	} posix_entry_t;

	typedef struct {
		logic req;
		logic [2:0] who;
		logic allow;
		logic [31:0] mask;
		logic [31:0] id;
		logic inh;
		logic ionly;
		logic typed;
		logic [2:0] tag;
	} ace_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic [2:0] who_kind = '0;
	logic is_allow = 1'b0;
	logic [31:0] ace_mask = '0;
	logic [31:0] principal_id = '0;
	logic inherits = 1'b0;
	logic inherit_only = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] entry_tag;
	logic [31:0] qualifier;
	logic may_read, may_write, may_execute, last_entry;

	nfs4_to_posix_acl_mapper #(.MAX_NAMED(NAMED_MAX)) u_dut (.*);

	always #1 clk = ~clk;

	// shadow of the mapper
	nfs4_acl_pkg::cfg_t acl_cfg;
	logic [31:0] own_a, own_d, grp_a, grp_d, oth_a, oth_d, all_a, all_d;
	nfs4_acl_pkg::named_t users[NAMED_MAX];
	nfs4_acl_pkg::named_t groups[NAMED_MAX];
	int n_users, n_groups;
	int unsigned kept;
	logic overflow;

	posix_entry_t pending_entries[$];
	int n_bad = 0;
	int send_idle = 25, recv_idle = 71;
	int quiet = 0;
	int finishes_seen = 0;

	function automatic logic [31:0] merge(logic [31:0] own, logic [31:0] opp,
			logic [31:0] m);
		return own | (m & ~opp);
	endfunction

	task automatic clear_acl();
		own_a = '0; own_d = '0; grp_a = '0; grp_d = '0;
		oth_a = '0; oth_d = '0; all_a = '0; all_d = '0;
		n_users = 0; n_groups = 0; kept = 0; overflow = 1'b0;
	endtask

	task automatic spread_users(logic [31:0] m);
		for (int i = 0; i < n_users; i++)
			users[i].allow = merge(users[i].allow, users[i].deny, m);
	endtask

	task automatic push_entry(logic [2:0] tag, logic [31:0] q, logic [31:0] perm,
			logic mapped, logic last);
		posix_entry_t e;
		logic [31:0] wm;
		wm = acl_cfg.write_bits | (acl_cfg.is_dir ? acl_cfg.del_bits : 32'd0);
		e.tag = tag; e.qual = q; e.last = last;
		e.rd = mapped && (perm & acl_cfg.read_bits) != 0;
		e.wr = mapped && (perm & wm) != 0;
		e.ex = mapped && (perm & acl_cfg.exec_bits) != 0;
		pending_entries.push_back(e);
	endtask

	task automatic fold_ace(logic [2:0] who, logic allow, logic [31:0] m,
			logic [31:0] id);
		int k;
		logic [31:0] s;
		k = -1;
		case (who)
			nfs4_acl_pkg::WHO_OWNER: begin
				if (allow) own_a = merge(own_a, own_d, m);
				else own_d = merge(own_d, own_a, m);
			end
			nfs4_acl_pkg::WHO_USER: begin
				for (int i = 0; i < n_users; i++)
					if (k < 0 && users[i].id == id) k = i;
				if (k < 0 && n_users < NAMED_MAX) begin
					k = n_users;
					users[k] = '{id, all_a, all_d};
					n_users++;
				end
				if (k < 0) overflow = 1'b1;
				else if (allow) begin
					users[k].allow = merge(users[k].allow, users[k].deny, m);
					own_a = merge(own_a, own_d, users[k].allow);
				end else users[k].deny = merge(users[k].deny, users[k].allow, m);
			end
			nfs4_acl_pkg::WHO_GROUP_OBJ: begin
				if (allow) begin
					grp_a = merge(grp_a, grp_d, m);
					s = grp_a;
					own_a = merge(own_a, own_d, s);
					all_a = merge(all_a, all_d, s);
					spread_users(s);
				end else grp_d = merge(grp_d, grp_a, m);
			end
			nfs4_acl_pkg::WHO_GROUP: begin
				for (int i = 0; i < n_groups; i++)
					if (k < 0 && groups[i].id == id) k = i;
				if (k < 0 && n_groups < NAMED_MAX) begin
					k = n_groups;
					groups[k] = '{id, oth_a, oth_d};
					n_groups++;
				end
				if (k < 0) overflow = 1'b1;
				else if (allow) begin
					groups[k].allow = merge(groups[k].allow, groups[k].deny, m);
					s = groups[k].allow;
					own_a = merge(own_a, own_d, s);
					all_a = merge(all_a, all_d, s);
					spread_users(s);
				end else groups[k].deny = merge(groups[k].deny, groups[k].allow, m);
			end
			nfs4_acl_pkg::WHO_EVERYONE: begin
				if (allow) begin
					own_a = merge(own_a, own_d, m);
					grp_a = merge(grp_a, grp_d, m);
					oth_a = merge(oth_a, oth_d, m);
					all_a = merge(all_a, all_d, m);
					spread_users(m);
					for (int i = 0; i < n_groups; i++)
						groups[i].allow = merge(groups[i].allow, groups[i].deny, m);
				end else begin
					own_d = merge(own_d, own_a, m);
					grp_d = merge(grp_d, grp_a, m);
					oth_d = merge(oth_d, oth_a, m);
					all_d = merge(all_d, all_a, m);
					for (int i = 0; i < n_users; i++)
						users[i].deny = merge(users[i].deny, users[i].allow, m);
					for (int i = 0; i < n_groups; i++)
						groups[i].deny = merge(groups[i].deny, groups[i].allow, m);
				end
			end
			default: ;
		endcase
	endtask

	task automatic predict_item(logic req, logic [2:0] who, logic allow,
			logic [31:0] m, logic [31:0] id, logic inh, logic ionly);
		logic [31:0] um;
		if (!req) begin
			if (acl_cfg.want_def ? !inh : ionly) return;
			if (kept < 65535) kept++;
			fold_ace(who, allow, m, id);
			return;
		end
		if ((acl_cfg.want_def && !acl_cfg.is_dir) || overflow)
			push_entry(nfs4_acl_pkg::TAG_ERROR, 32'd0, 32'd0, 1'b0, 1'b1);
		else if (acl_cfg.want_def && kept == 0)
			push_entry(nfs4_acl_pkg::TAG_EMPTY, 32'd0, 32'd0, 1'b0, 1'b1);
		else begin
			um = grp_a;
			push_entry(nfs4_acl_pkg::TAG_USER_OBJ, 32'd0, own_a, 1'b1, 1'b0);
			for (int i = 0; i < n_users; i++) begin
				push_entry(nfs4_acl_pkg::TAG_USER, users[i].id, users[i].allow, 1'b1, 1'b0);
				um |= users[i].allow;
			end
			push_entry(nfs4_acl_pkg::TAG_GROUP_OBJ, 32'd0, grp_a, 1'b1, 1'b0);
			for (int i = 0; i < n_groups; i++) begin
				push_entry(nfs4_acl_pkg::TAG_GROUP, groups[i].id, groups[i].allow, 1'b1, 1'b0);
				um |= groups[i].allow;
			end
			if (n_users != 0 || n_groups != 0)
				push_entry(nfs4_acl_pkg::TAG_MASK, 32'd0, um, 1'b1, 1'b0);
			push_entry(nfs4_acl_pkg::TAG_OTHER, 32'd0, oth_a, 1'b1, 1'b1);
		end
		clear_acl();
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin
		posix_entry_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_entries.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) $display("unexpected entry tag=%0d", entry_tag);
				end else begin
					e = pending_entries.pop_front();
					if (entry_tag !== e.tag || qualifier !== e.qual || may_read !== e.rd ||
							may_write !== e.wr || may_execute !== e.ex ||
							last_entry !== e.last) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch exp %0d %h %b%b%b %b got %0d %h %b%b%b %b",
								e.tag, e.qual, e.rd, e.wr, e.ex, e.last, entry_tag,
								qualifier, may_read, may_write, may_execute, last_entry);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(logic req, logic [2:0] who, logic allow,
			logic [31:0] m, logic [31:0] id, logic inh, logic ionly);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req; who_kind <= who; is_allow <= allow;
		ace_mask <= m; principal_id <= id; inherits <= inh; inherit_only <= ionly;
		predict_item(req, who, allow, m, id, inh, ionly);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(nfs4_acl_pkg::cfg_idx_t idx, logic [31:0] val);
		in_valid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			nfs4_acl_pkg::CFG_IS_DIR: acl_cfg.is_dir = val[0];
			nfs4_acl_pkg::CFG_WANT_DEF: acl_cfg.want_def = val[0];
			nfs4_acl_pkg::CFG_READ: acl_cfg.read_bits = val;
			nfs4_acl_pkg::CFG_WRITE: acl_cfg.write_bits = val;
			nfs4_acl_pkg::CFG_EXEC: acl_cfg.exec_bits = val;
			default: acl_cfg.del_bits = val;
		endcase
	endtask

	// random ACL: mostly small id pools so entries repeat, sometimes a flood
	task automatic random_acl(int n_ace);
		logic [31:0] id;
		logic [31:0] m;
		for (int i = 0; i < n_ace; i++) begin
			id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5);
			m = ($urandom_range(3) == 0) ? $urandom : (32'd1 << $urandom_range(7));
			send_item(1'b0, ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4)), 1'($urandom), m, id,
				($urandom_range(4) != 0), ($urandom_range(4) == 0));
		end
		send_item(1'b1, 3'($urandom), 1'($urandom), $urandom, $urandom,
			1'($urandom), 1'($urandom));
	endtask

	ace_row_t plan[$];
	int items;

	initial begin
		acl_cfg = '{1'b0, 1'b0, 32'd1, 32'd6, 32'd32, 32'd64};
		clear_acl();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			'{1'b1, 3'd0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1,
				nfs4_acl_pkg::TAG_USER_OBJ},
			'{1'b0, nfs4_acl_pkg::WHO_OWNER, 1'b1, 32'hFFFF_FFFF, 32'h0,
				1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_EVERYONE, 1'b0, 32'h0000_0026, 32'h0,
				1'b1, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_USER, 1'b1, 32'h0000_0021, 32'hFFFF_FFFF,
				1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_USER, 1'b0, 32'hFFFF_FFFF, 32'h0,
				1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_GROUP_OBJ, 1'b1, 32'h0000_0007, 32'h0,
				1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_GROUP, 1'b1, 32'h0000_0060, 32'hFFFF_FFFF,
				1'b1, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_GROUP, 1'b0, 32'h0000_0001, 32'h8000_0000,
				1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_EVERYONE, 1'b1, 32'h0000_00FF, 32'h0,
				1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, 3'd5, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, 3'd7, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0},
			'{1'b0, nfs4_acl_pkg::WHO_OWNER, 1'b0, 32'hFFFF_FFFF, 32'h0,
				1'b1, 1'b1, 1'b0, 3'd0},
			'{1'b1, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 3'd0}
		};
		foreach (plan[r]) begin
			send_item(plan[r].req, plan[r].who, plan[r].allow, plan[r].mask, plan[r].id,
				plan[r].inh, plan[r].ionly);
			if (plan[r].typed && pending_entries[0].tag !== plan[r].tag) begin
				n_bad++;
				if (n_bad <= 10)
					$display("directed row %0d exp tag %0d predicted tag %0d", r,
						plan[r].tag, pending_entries[0].tag);
			end
		end
		// default ACL on a file, then empty default ACL, then overflowing table
		write_reg(nfs4_acl_pkg::CFG_WANT_DEF, 32'd1);
		send_item(1'b1, 3'd0, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0);
		write_reg(nfs4_acl_pkg::CFG_IS_DIR, 32'hFFFF_FFFF);
		send_item(1'b0, nfs4_acl_pkg::WHO_OWNER, 1'b1, 32'h1, 32'd0, 1'b0, 1'b0);
		send_item(1'b1, 3'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0);
		for (int i = 0; i < NAMED_MAX + 1; i++)
			send_item(1'b0, nfs4_acl_pkg::WHO_USER, 1'b1, 32'h3, 32'(i), 1'b1, 1'b0);
		send_item(1'b1, 3'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0);
		for (int i = 0; i < NAMED_MAX; i++) begin
			send_item(1'b0, nfs4_acl_pkg::WHO_USER, 1'b1, 32'h2, 32'(i), 1'b1, 1'b1);
			send_item(1'b0, nfs4_acl_pkg::WHO_GROUP, 1'b0, 32'h40, 32'(100 + i),
				1'b1, 1'b1);
		end
		send_item(1'b1, 3'd0, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0);

		items = 0;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 25 : (phase == 1) ? 71 : 0;
			recv_idle = (phase == 0) ? 71 : (phase == 1) ? 25 : 0;
			write_reg(nfs4_acl_pkg::CFG_IS_DIR, 32'($urandom));
			write_reg(nfs4_acl_pkg::CFG_WANT_DEF, 32'($urandom));
			write_reg(nfs4_acl_pkg::CFG_READ, phase == 0 ? 32'hFFFF_FFFF : $urandom);
			write_reg(nfs4_acl_pkg::CFG_WRITE, phase == 0 ? 32'h0 : $urandom);
			write_reg(nfs4_acl_pkg::CFG_EXEC, $urandom);
			write_reg(nfs4_acl_pkg::CFG_DEL_CHILD, phase == 1 ? 32'hFFFF_FFFF : $urandom);
			for (int a = 0; a < 9; a++) begin
				if (a % 4 == 3) begin
					write_reg(nfs4_acl_pkg::CFG_WANT_DEF, 32'($urandom));
					write_reg(nfs4_acl_pkg::CFG_IS_DIR, 32'($urandom_range(3) != 0));
				end
				random_acl($urandom_range(1, 16));
			end
		end
		// long ACL walks into overflow on both tables
		write_reg(nfs4_acl_pkg::CFG_WANT_DEF, 32'd0);
		for (int i = 0; i < 40; i++)
			send_item(1'b0, i % 2 ? nfs4_acl_pkg::WHO_GROUP : nfs4_acl_pkg::WHO_USER,
				1'($urandom), $urandom, $urandom_range(20), 1'($urandom), 1'b0);
		send_item(1'b1, 3'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0);
		in_valid <= 1'b0;

		while (pending_entries.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (n_bad == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/nfs4_acl_pkg.sv
rtl/nfs4_acl_mapper_core.sv
rtl/nfs4_acl_cfg_regs.sv
rtl/nfs4_to_posix_acl_mapper.sv
tb/sv/nfs4_to_posix_acl_mapper_test.sv
